// ===== sv/ioa_pkg.sv =====
// ----------------------------------------------------------------------------
// ioa_pkg
// Shared types and constants for the interval overlap admission block.
// ----------------------------------------------------------------------------
package ioa_pkg;

  localparam int DefMaxPoints = 2048;
  localparam int DefTimeBits  = 30;
  localparam int DeltaBits    = 13;
  localparam int LimitBits    = 8;
  localparam logic [LimitBits-1:0] LimitReset = 8'd2;
  localparam logic [1:0] AddrLimit = 2'd0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, reset pointers
    logic scan;      // advance scan by one entry
    logic shift;     // advance insert-shift by one entry
    logic commit;    // finish update, bump count
  } ioa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    invalid;
    logic    scan_done;
    logic    over;
    logic    full;
    logic    shift_done;
  } ioa_sts_t;

endpackage

// ===== sv/ioa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ioa_ctrl
// Sequencer: scan pass, decision, rewrite pass, result strobe.
// ----------------------------------------------------------------------------
module ioa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ioa_pkg::ioa_sts_t sts,
  output ioa_pkg::ioa_cmd_t cmd,
  output logic              done,
  output logic              accepted,
  output logic [1:0]        status
);
  import ioa_pkg::*;

  state_t  state, state_next;
  status_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= ST_OK;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.invalid) begin
          res_next   = ST_INVALID;
          state_next = S_DONE;
        end else if (sts.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts.over) begin
          res_next   = ST_OVERLAP;
          state_next = S_DONE;
        end else if (sts.full) begin
          res_next   = ST_FULL;
          state_next = S_DONE;
        end else begin
          res_next   = ST_OK;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_DONE);
  assign accepted = done && (res == ST_OK);
  assign status   = done ? res : ST_OK;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_IDLE) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> res == ST_OK) else $error("commit on refused request");
endmodule

// ===== sv/ioa_dp.sv =====
// ----------------------------------------------------------------------------
// ioa_dp
// Point table with scan and rewrite passes. The rewrite copies the table
// from top down into itself, shifting entries to open slots for new points.
// ----------------------------------------------------------------------------
module ioa_dp #(
  parameter int MAX_POINTS = ioa_pkg::DefMaxPoints,
  parameter int TIME_BITS  = ioa_pkg::DefTimeBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ioa_pkg::ioa_cmd_t             cmd,
  output ioa_pkg::ioa_sts_t             sts,
  input  logic [TIME_BITS-1:0]          start_time,
  input  logic [TIME_BITS-1:0]          end_time,
  input  logic [ioa_pkg::LimitBits-1:0] limit
);
  import ioa_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int CovW = DeltaBits;

  logic [TIME_BITS-1:0] keys [MAX_POINTS];
  logic [DeltaBits-1:0] deltas [MAX_POINTS];

  logic [TIME_BITS-1:0] s, e;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;           // scan index / shift source count
  logic                 rd_v;          // read data valid
  logic [TIME_BITS-1:0] rk;
  logic [DeltaBits-1:0] rd;
  logic signed [CovW-1:0] cov, best;
  logic                 has_s, has_e, stop;
  logic [1:0]           need;
  logic [CW:0]          dst;           // write pointer for rewrite, plus one
  logic                 put_e, put_s;  // pending pseudo-points in rewrite
  logic                 rw_new_e, rw_new_s, rw_merge;

  logic [AW-1:0] raddr;
  logic          rd_req;
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [TIME_BITS-1:0] wkey;
  logic [DeltaBits-1:0] wdel;

  // scan reads ascending; rewrite reads descending, holding the entry
  // while a new point is written above it
  always_comb begin
    rd_req = 1'b0;
    raddr  = '0;
    if (cmd.scan && idx < count && !stop) begin
      rd_req = 1'b1;
      raddr  = idx[AW-1:0];
    end else if (cmd.load) begin
      rd_req = 1'b0;
    end else if (cmd.shift && idx != '0 && (!rd_v || rw_merge)) begin
      rd_req = 1'b1;
      raddr  = AW'(idx - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req) begin
      rk <= keys[raddr];
      rd <= deltas[raddr];
    end
    if (wr_en) begin
      keys[waddr]   <= wkey;
      deltas[waddr] <= wdel;
    end
  end

  logic signed [CovW-1:0] cov_add, best_a, best_b;
  assign cov_add = cov + CovW'(signed'(rd));
  always_comb begin
    best_a = best;
    if (rk > s && cov > best_a) best_a = cov;
    best_b = best_a;
    if (rk >= s && cov_add > best_b) best_b = cov_add;
  end

  // rewrite step: read entry is in rk/rd when rd_v
  always_comb begin
    wr_en = 1'b0; waddr = '0; wkey = rk; wdel = rd;
    rw_new_e = 1'b0; rw_new_s = 1'b0; rw_merge = 1'b0;
    if (cmd.shift) begin
      if (put_e && (rd_v ? (rk < e) : (idx == '0))) begin
        rw_new_e = 1'b1; wr_en = 1'b1; wkey = e; wdel = '1;
      end else if (!put_e && put_s && (rd_v ? (rk < s) : (idx == '0))) begin
        rw_new_s = 1'b1; wr_en = 1'b1; wkey = s; wdel = DeltaBits'(1);
      end else if (rd_v) begin
        rw_merge = 1'b1; wr_en = 1'b1;
        if (rk == e) wdel = rd - 1'b1;
        else if (rk == s) wdel = rd + 1'b1;
      end
      waddr = AW'(dst - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= CW'(count + need);
    end
    if (cmd.load) begin
      s <= start_time; e <= end_time;
      idx <= '0; rd_v <= 1'b0; cov <= '0; best <= '0;
      has_s <= 1'b0; has_e <= 1'b0; stop <= 1'b0;
    end else if (cmd.scan) begin
      rd_v <= rd_req && !(rd_v && rk >= e);
      if (rd_req) idx <= idx + 1'b1;
      if (rd_v) begin
        if (rk == s) has_s <= 1'b1;
        if (rk == e) has_e <= 1'b1;
        if (rk >= e) begin
          stop <= 1'b1;
        end else begin
          cov  <= cov_add;
          best <= best_b;
        end
      end
    end else if (cmd.shift) begin
      if (rw_new_e) put_e <= 1'b0;
      if (rw_new_s) put_s <= 1'b0;
      if (wr_en) dst <= dst - 1'b1;
      if (!rd_v || rw_merge) begin
        rd_v <= rd_req;
        if (rd_req) idx <= idx - 1'b1;
      end
    end else begin
      // idle, decide and done cycles: prime rewrite
      idx   <= count;
      rd_v  <= 1'b0;
      put_e <= !has_e;
      put_s <= !has_s;
      dst   <= (CW+1)'(count) + (CW+1)'(need);
      if (cov > best) best <= cov;
    end
  end

  logic signed [CovW-1:0] best_f;
  assign best_f = (cov > best) ? cov : best;
  assign need   = {1'b0, !has_s} + {1'b0, !has_e};

  assign sts.invalid    = (s >= e);
  assign sts.scan_done  = stop || (!rd_v && idx >= count);
  assign sts.over       = best_f >= CovW'(signed'({1'b0, limit}));
  assign sts.full       = ((CW+1)'(count) + (CW+1)'(need)) > (CW+1)'(MAX_POINTS);
  assign sts.shift_done = (dst == '0) || (!put_e && !put_s && !rd_v && idx == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS)) else $error("point count beyond table");
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.full) else $error("commit overflows table");
  a_no_mix: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan && cmd.shift)) else $error("scan and shift together");
endmodule

// ===== sv/interval_overlap_admission.sv =====
// ----------------------------------------------------------------------------
// interval_overlap_admission
// Booking admission by sweep-line maximum overlap over a sorted point table.
// ----------------------------------------------------------------------------
// channel   signals                          direction
// request   start, busy, start_time, end_time in (start/busy handshake)
// result    done, accepted, status            out (one-cycle strobe)
// config    psel penable pwrite paddr pwdata  APB, overlap_limit at 0x0
//
// The scan stops at the first key >= end_time and is followed by a decide
// state; an admitted request then rewrites the table (need = new points),
// and the result strobe follows in S_DONE. Pass lengths are set by the
// single table read port. A new request is taken only after done (busy low).
// Reset clears the point count and sets overlap_limit to 2.
// The result strobe cannot be stalled; busy holds off new requests.
// ----------------------------------------------------------------------------
module interval_overlap_admission #(
  parameter int MAX_POINTS = ioa_pkg::DefMaxPoints,
  parameter int TIME_BITS  = ioa_pkg::DefTimeBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  output logic                 done,
  output logic                 accepted,
  output logic [1:0]           status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import ioa_pkg::*;

  logic [LimitBits-1:0] limit;
  ioa_cmd_t cmd;
  ioa_sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (psel && penable && pwrite && paddr == AddrLimit) begin
      limit <= pwdata[LimitBits-1:0];
    end
  end
  assign prdata = (paddr == AddrLimit) ? {24'd0, limit} : 32'd0;

  ioa_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .sts, .cmd, .done, .accepted, .status
  );

  ioa_dp #(.MAX_POINTS(MAX_POINTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .start_time, .end_time, .limit
  );
endmodule
